### src/psm_pkg.sv
package psm_pkg;

   // Default grid side, in pixels.
   localparam int DEF_MAX_SIDE = 256;

   // Command codes.
   localparam logic [2:0] CMD_WRITE    = 3'd0;
   localparam logic [2:0] CMD_READ     = 3'd1;
   localparam logic [2:0] CMD_GROW     = 3'd2;
   localparam logic [2:0] CMD_CLASSIFY = 3'd3;
   localparam logic [2:0] CMD_COUNT    = 3'd4;
   // Codes above the last command are unused and rejected.
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

   // Pixel classes.
   localparam logic [1:0] CLS_OUT    = 2'd0;
   localparam logic [1:0] CLS_BORDER = 2'd1;
   localparam logic [1:0] CLS_IN     = 2'd2;
   localparam logic [1:0] CLS_THREE  = 2'd3;

   // Classify verdicts.
   localparam logic [1:0] VERDICT_IN    = 2'd0;
   localparam logic [1:0] VERDICT_OUT   = 2'd1;
   localparam logic [1:0] VERDICT_MIXED = 2'd2;

   // Grow sides, in the order they are visited in each round.
   localparam logic [1:0] SIDE_LEFT   = 2'd0;
   localparam logic [1:0] SIDE_BOTTOM = 2'd1;
   localparam logic [1:0] SIDE_RIGHT  = 2'd2;
   localparam logic [1:0] SIDE_TOP    = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LAST_COLUMN = 2'd0;
   localparam logic [1:0] CSR_LAST_ROW    = 2'd1;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] end_x;
      logic [7:0] end_y;
      logic [1:0] class_code;
   } req_type;

   typedef struct packed {
      logic [1:0]  read_class;
      logic [7:0]  rect_low_x;
      logic [7:0]  rect_low_y;
      logic [7:0]  rect_high_x;
      logic [7:0]  rect_high_y;
      logic [1:0]  verdict;
      logic [16:0] pixel_count;
      logic        error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_GROW_SIDE,
      ST_DONE
   } state_type;

endpackage

### src/pixel_status_map_rect_grow_unit.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_data  (psm_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data  (psm_pkg::rsp_type)
// csr       in         csr_valid / csr_ready  csr_index, csr_data
//
// After reset the pixel memory is swept to "out", one entry per cycle, over all
// MAX_SIDE*MAX_SIDE entries (65536 at the default); no request is taken meanwhile.
// A write passes the start and done states before its result is registered; a read adds
// a read and an evaluate state, as does each pixel visited by grow, classify or count,
// since the single read port is used once per pixel. Count visits every used pixel.
// One request is worked on at a time. A finished result waits in the output register,
// so the next request is accepted while the previous result is still stalled.
module pixel_status_map_rect_grow_unit #(
   parameter int MAX_SIDE = psm_pkg::DEF_MAX_SIDE
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  psm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output psm_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_data
);

   // The memory is addressed as row * MAX_SIDE + column.
   localparam int AW    = 2 * $clog2(MAX_SIDE);
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int CAP_I = (MAX_SIDE - 1 > 255) ? 255 : MAX_SIDE - 1;
   localparam logic [7:0]    CAP      = CAP_I[7:0];
   localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);
   localparam logic [AW-1:0] SIDE_W   = AW'(MAX_SIDE);

   psm_pkg::state_type state_ff, state_in;

   logic [7:0] last_column_ff, last_column_in;
   logic [7:0] last_row_ff, last_row_in;

   psm_pkg::req_type req_ff, req_in;
   psm_pkg::rsp_type res_ff, res_in;
   psm_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0] clr_ff, clr_in;

   // Walk over a pixel rectangle, columns inner.
   logic [7:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [7:0] wx0_ff, wx0_in, wx1_ff, wx1_in, wy1_ff, wy1_in;

   // Grow state.
   logic [7:0] lo_x_ff, lo_x_in, lo_y_ff, lo_y_in, hi_x_ff, hi_x_in, hi_y_ff, hi_y_in;
   logic [3:0] stop_ff, stop_in;
   logic [1:0] side_ff, side_in;
   logic       run_ff, run_in;

   // Classify and count accumulators.
   logic        not_in_ff, not_in_in, not_out_ff, not_out_in;
   logic [16:0] count_ff, count_in;

   // Memory.
   logic [1:0]    mem [DEPTH];
   logic [1:0]    rd_ff;
   logic          mem_we;
   logic [AW-1:0] waddr, raddr;
   logic [1:0]    wdata;

   // Shared decisions.
   logic [7:0] mx, my;
   logic       on_grid, cls_off, cls_empty;
   logic       walk_last, pix_not_in, walk_end, side_blocked, side_done, grow_fin;
   logic       slot_free, new_not_in, new_not_out;
   logic [3:0] stop_new;
   logic [2:0] cmd;

   assign req_ready = (state_ff == psm_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      mx  = (last_column_ff < CAP) ? last_column_ff : CAP;
      my  = (last_row_ff < CAP) ? last_row_ff : CAP;
      cmd = req_ff.command;
      on_grid   = (req_ff.pos_x <= mx) && (req_ff.pos_y <= my);
      cls_off   = !on_grid || (req_ff.end_x > mx) || (req_ff.end_y > my);
      cls_empty = (req_ff.pos_x > req_ff.end_x) || (req_ff.pos_y > req_ff.end_y);
      walk_last  = (cx_ff == wx1_ff) && (cy_ff == wy1_ff);
      pix_not_in = (rd_ff != psm_pkg::CLS_IN);
      walk_end   = walk_last || pix_not_in;
      new_not_in  = not_in_ff || (rd_ff != psm_pkg::CLS_IN);
      new_not_out = not_out_ff || (rd_ff != psm_pkg::CLS_OUT);
      slot_free   = !rsp_valid_ff || rsp_ready;

      // A side is blocked when the next line would leave the grid.
      unique case (side_ff)
         psm_pkg::SIDE_LEFT:   side_blocked = (lo_x_ff == 8'd0);
         psm_pkg::SIDE_BOTTOM: side_blocked = (lo_y_ff == 8'd0);
         psm_pkg::SIDE_RIGHT:  side_blocked = (hi_x_ff >= mx);
         default:              side_blocked = (hi_y_ff >= my);
      endcase

      side_done = 1'b0;
      stop_new  = stop_ff;
      if (state_ff == psm_pkg::ST_GROW_SIDE) begin
         side_done = stop_ff[side_ff] || side_blocked;
         if (side_done) begin
            stop_new[side_ff] = 1'b1;
         end
      end else if (state_ff == psm_pkg::ST_WALK_EV && cmd == psm_pkg::CMD_GROW && run_ff) begin
         side_done = walk_end;
         if (pix_not_in) begin
            stop_new[side_ff] = 1'b1;
         end
      end
      // The loop only ends after the top side of a round.
      grow_fin = side_done && (side_ff == psm_pkg::SIDE_TOP) && (&stop_new);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psm_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_ADR) begin
               state_in = psm_pkg::ST_IDLE;
            end
         end
         psm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = psm_pkg::ST_START;
            end
         end
         psm_pkg::ST_START: begin
            priority case (cmd)
               psm_pkg::CMD_READ, psm_pkg::CMD_GROW:
                  state_in = on_grid ? psm_pkg::ST_WALK_RD : psm_pkg::ST_DONE;
               psm_pkg::CMD_CLASSIFY:
                  state_in = (cls_off || cls_empty) ? psm_pkg::ST_DONE : psm_pkg::ST_WALK_RD;
               psm_pkg::CMD_COUNT:
                  state_in = psm_pkg::ST_WALK_RD;
               default:
                  state_in = psm_pkg::ST_DONE;
            endcase
         end
         psm_pkg::ST_WALK_RD: state_in = psm_pkg::ST_WALK_EV;
         psm_pkg::ST_WALK_EV: begin
            if (cmd == psm_pkg::CMD_READ) begin
               state_in = psm_pkg::ST_DONE;
            end else if (cmd == psm_pkg::CMD_GROW && !run_ff) begin
               state_in = pix_not_in ? psm_pkg::ST_DONE : psm_pkg::ST_GROW_SIDE;
            end else if (cmd == psm_pkg::CMD_GROW) begin
               if (grow_fin) begin
                  state_in = psm_pkg::ST_DONE;
               end else if (side_done) begin
                  state_in = psm_pkg::ST_GROW_SIDE;
               end else begin
                  state_in = psm_pkg::ST_WALK_RD;
               end
            end else begin
               state_in = walk_last ? psm_pkg::ST_DONE : psm_pkg::ST_WALK_RD;
            end
         end
         psm_pkg::ST_GROW_SIDE: begin
            if (grow_fin) begin
               state_in = psm_pkg::ST_DONE;
            end else if (side_done) begin
               state_in = psm_pkg::ST_GROW_SIDE;
            end else begin
               state_in = psm_pkg::ST_WALK_RD;
            end
         end
         psm_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = psm_pkg::ST_IDLE;
            end
         end
         default: state_in = psm_pkg::ST_CLEAR;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      last_column_in = last_column_ff;
      last_row_in    = last_row_ff;
      req_in   = req_ff;
      res_in   = res_ff;
      clr_in   = clr_ff;
      cx_in = cx_ff;   cy_in = cy_ff;
      wx0_in = wx0_ff; wx1_in = wx1_ff; wy1_in = wy1_ff;
      lo_x_in = lo_x_ff; lo_y_in = lo_y_ff; hi_x_in = hi_x_ff; hi_y_in = hi_y_ff;
      stop_in = stop_ff;
      side_in = side_ff;
      run_in  = run_ff;
      not_in_in  = not_in_ff;
      not_out_in = not_out_ff;
      count_in   = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we = 1'b0;
      waddr  = AW'(req_ff.pos_y) * SIDE_W + AW'(req_ff.pos_x);
      raddr  = AW'(cy_ff) * SIDE_W + AW'(cx_ff);
      wdata  = (req_ff.class_code == psm_pkg::CLS_THREE) ? psm_pkg::CLS_BORDER
                                                         : req_ff.class_code;

      if (csr_valid) begin
         if (csr_index == psm_pkg::CSR_LAST_COLUMN) begin
            last_column_in = csr_data;
         end else if (csr_index == psm_pkg::CSR_LAST_ROW) begin
            last_row_in = csr_data;
         end
      end

      unique case (state_ff)
         psm_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            waddr  = clr_ff;
            wdata  = psm_pkg::CLS_OUT;
            clr_in = clr_ff + 1'b1;
         end
         psm_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         psm_pkg::ST_START: begin
            res_in     = '0;
            run_in     = 1'b0;
            not_in_in  = 1'b0;
            not_out_in = 1'b0;
            count_in   = '0;
            cx_in  = req_ff.pos_x; cy_in  = req_ff.pos_y;
            wx0_in = req_ff.pos_x; wx1_in = req_ff.pos_x;
            wy1_in = req_ff.pos_y;
            priority case (cmd)
               psm_pkg::CMD_WRITE: begin
                  if (on_grid) begin
                     mem_we = 1'b1;
                  end else begin
                     res_in.error = 1'b1;
                  end
               end
               psm_pkg::CMD_READ, psm_pkg::CMD_GROW: begin
                  res_in.error = !on_grid;
               end
               psm_pkg::CMD_CLASSIFY: begin
                  wx1_in = req_ff.end_x;
                  wy1_in = req_ff.end_y;
                  if (cls_off) begin
                     res_in.error   = 1'b1;
                     res_in.verdict = psm_pkg::VERDICT_OUT;
                  end
               end
               psm_pkg::CMD_COUNT: begin
                  cx_in = 8'd0; cy_in = 8'd0;
                  wx0_in = 8'd0;
                  wx1_in = mx;   wy1_in = my;
               end
               default: res_in.error = 1'b1;
            endcase
         end
         psm_pkg::ST_WALK_RD: begin
         end
         psm_pkg::ST_WALK_EV: begin
            // Step to the next pixel of the walk.
            if (cx_ff == wx1_ff) begin
               cx_in = wx0_ff;
               cy_in = cy_ff + 8'd1;
            end else begin
               cx_in = cx_ff + 8'd1;
            end
            if (cmd == psm_pkg::CMD_READ) begin
               res_in.read_class = rd_ff;
            end else if (cmd == psm_pkg::CMD_GROW && !run_ff) begin
               if (pix_not_in) begin
                  res_in.error = 1'b1;
               end else begin
                  lo_x_in = req_ff.pos_x; hi_x_in = req_ff.pos_x;
                  lo_y_in = req_ff.pos_y; hi_y_in = req_ff.pos_y;
                  stop_in = '0;
                  side_in = psm_pkg::SIDE_LEFT;
                  run_in  = 1'b1;
               end
            end else if (cmd == psm_pkg::CMD_GROW) begin
               if (side_done) begin
                  stop_in = stop_new;
                  side_in = side_ff + 2'd1;
                  if (!pix_not_in) begin
                     unique case (side_ff)
                        psm_pkg::SIDE_LEFT:   lo_x_in = lo_x_ff - 8'd1;
                        psm_pkg::SIDE_BOTTOM: lo_y_in = lo_y_ff - 8'd1;
                        psm_pkg::SIDE_RIGHT:  hi_x_in = hi_x_ff + 8'd1;
                        default:              hi_y_in = hi_y_ff + 8'd1;
                     endcase
                  end
               end
            end else if (cmd == psm_pkg::CMD_CLASSIFY) begin
               not_in_in  = new_not_in;
               not_out_in = new_not_out;
               if (!new_not_in) begin
                  res_in.verdict = psm_pkg::VERDICT_IN;
               end else if (!new_not_out) begin
                  res_in.verdict = psm_pkg::VERDICT_OUT;
               end else begin
                  res_in.verdict = psm_pkg::VERDICT_MIXED;
               end
            end else begin
               if (rd_ff == req_ff.class_code) begin
                  count_in = count_ff + 17'd1;
               end
               res_in.pixel_count = count_in;
            end
         end
         psm_pkg::ST_GROW_SIDE: begin
            if (side_done) begin
               stop_in = stop_new;
               side_in = side_ff + 2'd1;
            end else begin
               unique case (side_ff)
                  psm_pkg::SIDE_LEFT: begin
                     cx_in = lo_x_ff - 8'd1; wx0_in = cx_in; wx1_in = cx_in;
                     cy_in = lo_y_ff; wy1_in = hi_y_ff;
                  end
                  psm_pkg::SIDE_BOTTOM: begin
                     cy_in = lo_y_ff - 8'd1; wy1_in = cy_in;
                     cx_in = lo_x_ff; wx0_in = lo_x_ff; wx1_in = hi_x_ff;
                  end
                  psm_pkg::SIDE_RIGHT: begin
                     cx_in = hi_x_ff + 8'd1; wx0_in = cx_in; wx1_in = cx_in;
                     cy_in = lo_y_ff; wy1_in = hi_y_ff;
                  end
                  default: begin
                     cy_in = hi_y_ff + 8'd1; wy1_in = cy_in;
                     cx_in = lo_x_ff; wx0_in = lo_x_ff; wx1_in = hi_x_ff;
                  end
               endcase
            end
         end
         psm_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // The rectangle stands final once every side has stopped.
      if (grow_fin) begin
         res_in.rect_low_x  = lo_x_ff;
         res_in.rect_low_y  = lo_y_ff;
         res_in.rect_high_x = hi_x_ff;
         res_in.rect_high_y = hi_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= psm_pkg::ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         last_column_ff <= 8'd255;
         last_row_ff    <= 8'd255;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_column_ff <= last_column_in;
         last_row_ff    <= last_row_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      cx_ff  <= cx_in;  cy_ff  <= cy_in;
      wx0_ff <= wx0_in; wx1_ff <= wx1_in; wy1_ff <= wy1_in;
      lo_x_ff <= lo_x_in; lo_y_ff <= lo_y_in; hi_x_ff <= hi_x_in; hi_y_ff <= hi_y_in;
      stop_ff <= stop_in;
      side_ff <= side_in;
      run_ff  <= run_in;
      not_in_ff  <= not_in_in;
      not_out_ff <= not_out_in;
      count_ff   <= count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   // No request is taken while the memory is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == psm_pkg::ST_CLEAR |-> !req_ready)
      else $error("request accepted during clearing pass");

   // The memory is written only by the clearing pass or a write command.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == psm_pkg::ST_CLEAR || state_ff == psm_pkg::ST_START))
      else $error("memory written outside clear or write");

   // The growing rectangle never turns inside out.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == psm_pkg::ST_GROW_SIDE |-> (lo_x_ff <= hi_x_ff && lo_y_ff <= hi_y_ff))
      else $error("grow rectangle corners crossed");

endmodule

### sim/pixel_status_map_rect_grow_unit_checker.sv
`timescale 1ns / 1ps

// Watches the three channels, keeps its own copy of the class map and limits,
// and compares every accepted result against the oldest prediction.
module pixel_status_map_rect_grow_unit_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  psm_pkg::req_type    req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  psm_pkg::rsp_type    rsp_data,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data,
   output int                  fail_count,
   output int                  pending
);

   logic [1:0] class_map [0:65535];
   logic [7:0] col_limit;
   logic [7:0] row_limit;
   psm_pkg::rsp_type outcome_q [$];

   function automatic logic [1:0] pixel_at(int x, int y);
      return class_map[16'(y * 256 + x)];
   endfunction

   function automatic bit column_all_in(int x, int y0, int y1);
      for (int y = y0; y <= y1; y++)
         if (pixel_at(x, y) != psm_pkg::CLS_IN) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit row_all_in(int y, int x0, int x1);
      for (int x = x0; x <= x1; x++)
         if (pixel_at(x, y) != psm_pkg::CLS_IN) return 1'b0;
      return 1'b1;
   endfunction

   // Works out the result of one request and applies any write to the map.
   function automatic psm_pkg::rsp_type map_outcome(psm_pkg::req_type r);
      psm_pkg::rsp_type o;
      int mx, my, lx, ly, hx, hy, total, n_in, n_out, n;
      bit on_grid, sl, sb, sr, st;
      logic [1:0] c;
      o = '0;
      mx = int'(col_limit);
      my = int'(row_limit);
      on_grid = int'(r.pos_x) <= mx && int'(r.pos_y) <= my;
      case (r.command)
         psm_pkg::CMD_WRITE: begin
            if (!on_grid) o.error = 1'b1;
            else class_map[16'(int'(r.pos_y) * 256 + int'(r.pos_x))] =
               (r.class_code == psm_pkg::CLS_THREE) ? psm_pkg::CLS_BORDER : r.class_code;
         end
         psm_pkg::CMD_READ: begin
            if (!on_grid) o.error = 1'b1;
            else o.read_class = pixel_at(int'(r.pos_x), int'(r.pos_y));
         end
         psm_pkg::CMD_GROW: begin
            if (!on_grid || pixel_at(int'(r.pos_x), int'(r.pos_y)) != psm_pkg::CLS_IN) begin
               o.error = 1'b1;
            end else begin
               lx = int'(r.pos_x); hx = int'(r.pos_x); ly = int'(r.pos_y); hy = int'(r.pos_y);
               sl = 1'b0; sb = 1'b0; sr = 1'b0; st = 1'b0;
               while (!sl || !sb || !sr || !st) begin
                  if (!sl) begin
                     if (lx == 0 || !column_all_in(lx - 1, ly, hy)) sl = 1'b1;
                     else lx--;
                  end
                  if (!sb) begin
                     if (ly == 0 || !row_all_in(ly - 1, lx, hx)) sb = 1'b1;
                     else ly--;
                  end
                  if (!sr) begin
                     if (hx >= mx || !column_all_in(hx + 1, ly, hy)) sr = 1'b1;
                     else hx++;
                  end
                  if (!st) begin
                     if (hy >= my || !row_all_in(hy + 1, lx, hx)) st = 1'b1;
                     else hy++;
                  end
               end
               o.rect_low_x = 8'(lx); o.rect_low_y = 8'(ly);
               o.rect_high_x = 8'(hx); o.rect_high_y = 8'(hy);
            end
         end
         psm_pkg::CMD_CLASSIFY: begin
            if (!on_grid || int'(r.end_x) > mx || int'(r.end_y) > my) begin
               o.error = 1'b1;
               o.verdict = psm_pkg::VERDICT_OUT;
            end else begin
               total = 0; n_in = 0; n_out = 0;
               if (r.pos_x <= r.end_x && r.pos_y <= r.end_y)
                  for (int x = int'(r.pos_x); x <= int'(r.end_x); x++)
                     for (int y = int'(r.pos_y); y <= int'(r.end_y); y++) begin
                        c = pixel_at(x, y);
                        total++;
                        if (c == psm_pkg::CLS_IN) n_in++;
                        else if (c == psm_pkg::CLS_OUT) n_out++;
                     end
               if (n_in == total) o.verdict = psm_pkg::VERDICT_IN;
               else if (n_out == total) o.verdict = psm_pkg::VERDICT_OUT;
               else o.verdict = psm_pkg::VERDICT_MIXED;
            end
         end
         psm_pkg::CMD_COUNT: begin
            n = 0;
            for (int y = 0; y <= my; y++)
               for (int x = 0; x <= mx; x++)
                  if (pixel_at(x, y) == r.class_code) n++;
            o.pixel_count = 17'(n);
         end
         default: o.error = 1'b1;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      psm_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < 65536; i++) class_map[16'(i)] = psm_pkg::CLS_OUT;
         col_limit = 8'd255;
         row_limit = 8'd255;
         outcome_q.delete();
         fail_count = 0;
         pending = 0;
      end else begin
         // The result leaves before a new request is predicted, so a request
         // accepted in the same cycle can never be matched against itself.
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $error("result with no request outstanding");
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_data.read_class !== want.read_class) begin
                  $error("read_class: expected %0d, got %0d", want.read_class,
                         rsp_data.read_class);
                  fail_count++;
               end
               if (rsp_data.rect_low_x !== want.rect_low_x) begin
                  $error("rect_low_x: expected %0d, got %0d", want.rect_low_x,
                         rsp_data.rect_low_x);
                  fail_count++;
               end
               if (rsp_data.rect_low_y !== want.rect_low_y) begin
                  $error("rect_low_y: expected %0d, got %0d", want.rect_low_y,
                         rsp_data.rect_low_y);
                  fail_count++;
               end
               if (rsp_data.rect_high_x !== want.rect_high_x) begin
                  $error("rect_high_x: expected %0d, got %0d", want.rect_high_x,
                         rsp_data.rect_high_x);
                  fail_count++;
               end
               if (rsp_data.rect_high_y !== want.rect_high_y) begin
                  $error("rect_high_y: expected %0d, got %0d", want.rect_high_y,
                         rsp_data.rect_high_y);
                  fail_count++;
               end
               if (rsp_data.verdict !== want.verdict) begin
                  $error("verdict: expected %0d, got %0d", want.verdict, rsp_data.verdict);
                  fail_count++;
               end
               if (rsp_data.pixel_count !== want.pixel_count) begin
                  $error("pixel_count: expected %0d, got %0d", want.pixel_count,
                         rsp_data.pixel_count);
                  fail_count++;
               end
               if (rsp_data.error !== want.error) begin
                  $error("error: expected %0d, got %0d", want.error, rsp_data.error);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            outcome_q.insert(outcome_q.size(), map_outcome(req_data));
         if (csr_valid && csr_ready) begin
            if (csr_index == psm_pkg::CSR_LAST_COLUMN) col_limit = csr_data;
            else if (csr_index == psm_pkg::CSR_LAST_ROW) row_limit = csr_data;
         end
         pending = outcome_q.size();
      end
   end

endmodule

### sim/pixel_status_map_rect_grow_unit_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the pixel class map. Prediction and comparison live
// in the checker module instantiated beside the block.
module pixel_status_map_rect_grow_unit_tb;

   // The longest quiet stretch is the reset sweep or a full-grid walk over
   // 65536 pixels, plus receiver stalls.
   localparam int QUIET_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   psm_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   psm_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   int fail_count;
   int pending;
   int quiet_cycles = 0;
   int sent = 0;
   int settings_used = 0;
   bit no_idle = 1'b0;
   int col_lim = 255;
   int row_lim = 255;

   always #5 clock = ~clock;

   pixel_status_map_rect_grow_unit u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   pixel_status_map_rect_grow_unit_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending
   );

   // Watchdog: counts cycles in which no channel moves anything.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("pixel_status_map_rect_grow_unit: mismatch");
         $finish;
      end
   end

   // Result side: each result waits out a random stall before ready rises,
   // unless the current stretch runs without idling.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Sends one request. Valid stays high after acceptance only when the next
   // request follows with no gap, so it is never dropped and raised in one step.
   task automatic send_request(psm_pkg::req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sent++;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue(logic [2:0] cmd, int x, int y, int ex, int ey, logic [1:0] code);
      psm_pkg::req_type r;
      r.command = cmd;
      r.pos_x = 8'(x); r.pos_y = 8'(y); r.end_x = 8'(ex); r.end_y = 8'(ey);
      r.class_code = code;
      send_request(r);
   endtask

   // Drops valid and waits until every outstanding result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 8'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Limits change only with the block idle: every request yields a result,
   // so a drain plus a short settle is enough.
   task automatic set_limits(int col, int row);
      drain();
      repeat (20) @(posedge clock);
      write_register(psm_pkg::CSR_LAST_COLUMN, col);
      write_register(psm_pkg::CSR_LAST_ROW, row);
      col_lim = col;
      row_lim = row;
      settings_used++;
   endtask

   // Mostly on the grid, sometimes anywhere in the 8-bit range.
   function automatic int pick_coord(int lim);
      return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, lim);
   endfunction

   // Paints a small block of inside pixels, sometimes overwrites one of them with
   // border or out, then grows from a point in it and classifies it, so grow can walk several rounds.
   task automatic paint_and_grow();
      int x0, y0, x1, y1;
      x0 = $urandom_range(0, col_lim);
      y0 = $urandom_range(0, row_lim);
      x1 = x0 + $urandom_range(0, 3);
      y1 = y0 + $urandom_range(0, 3);
      if (x1 > col_lim) x1 = col_lim;
      if (y1 > row_lim) y1 = row_lim;
      for (int y = y0; y <= y1; y++)
         for (int x = x0; x <= x1; x++)
            issue(psm_pkg::CMD_WRITE, x, y, 0, 0, psm_pkg::CLS_IN);
      if ($urandom_range(0, 2) == 0)
         issue(psm_pkg::CMD_WRITE, $urandom_range(x0, x1), $urandom_range(y0, y1), 0, 0,
               $urandom_range(0, 1) ? psm_pkg::CLS_BORDER : psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_GROW, $urandom_range(x0, x1), $urandom_range(y0, y1), 0, 0,
            2'($urandom_range(0, 3)));
      issue(psm_pkg::CMD_CLASSIFY, x0, y0, x1, y1, psm_pkg::CLS_OUT);
   endtask

   task automatic random_request(bit allow_count);
      int pick;
      logic [2:0] cmd;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: cmd = psm_pkg::CMD_WRITE;
         3:       cmd = psm_pkg::CMD_READ;
         4, 5:    cmd = psm_pkg::CMD_GROW;
         6:       cmd = psm_pkg::CMD_CLASSIFY;
         7:       cmd = allow_count ? psm_pkg::CMD_COUNT : psm_pkg::CMD_READ;
         8:       cmd = 3'($urandom_range(int'(psm_pkg::CMD_UNUSED_LO),
                                          int'(psm_pkg::CMD_UNUSED_HI)));
         default: cmd = psm_pkg::CMD_WRITE;
      endcase
      issue(cmd, pick_coord(col_lim), pick_coord(row_lim), pick_coord(col_lim),
            pick_coord(row_lim), 2'($urandom_range(0, 3)));
   endtask

   task automatic random_phase(int col, int row, int n, bit allow_count);
      int start;
      set_limits(col, row);
      start = sent;
      while (sent - start < n) begin
         // Alternate stretches with and without idling on both sides.
         if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
         if ((sent - start) > n / 2 && (sent - start) < n / 2 + 8 && $urandom_range(0, 1))
            drain();
         if ($urandom_range(0, 1)) paint_and_grow();
         else random_request(allow_count);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the full 256 x 256 grid, reset limits.
      issue(psm_pkg::CMD_WRITE, 0, 0, 0, 0, psm_pkg::CLS_IN);
      issue(psm_pkg::CMD_WRITE, 255, 255, 0, 0, psm_pkg::CLS_IN);
      issue(psm_pkg::CMD_WRITE, 255, 254, 0, 0, psm_pkg::CLS_IN);
      issue(psm_pkg::CMD_WRITE, 1, 0, 0, 0, psm_pkg::CLS_THREE);   // stored as border
      issue(psm_pkg::CMD_READ, 255, 255, 0, 0, psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_READ, 1, 0, 0, 0, psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_GROW, 255, 255, 0, 0, psm_pkg::CLS_OUT);  // stops at the grid corner
      issue(psm_pkg::CMD_GROW, 0, 0, 0, 0, psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_GROW, 1, 0, 0, 0, psm_pkg::CLS_OUT);      // border start is rejected
      issue(psm_pkg::CMD_GROW, 5, 5, 0, 0, psm_pkg::CLS_OUT);      // out start is rejected
      issue(psm_pkg::CMD_CLASSIFY, 0, 0, 0, 0, psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_CLASSIFY, 0, 0, 1, 0, psm_pkg::CLS_OUT);  // border makes it mixed
      issue(psm_pkg::CMD_CLASSIFY, 5, 5, 6, 6, psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_CLASSIFY, 3, 0, 2, 0, psm_pkg::CLS_OUT);  // empty rectangle is all in
      issue(psm_pkg::CMD_CLASSIFY, 0, 0, 255, 255, psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_COUNT, 0, 0, 0, 0, psm_pkg::CLS_IN);
      issue(psm_pkg::CMD_UNUSED_LO, 0, 0, 0, 0, psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_UNUSED_HI, 255, 255, 255, 255, psm_pkg::CLS_THREE);

      // Off-grid handling needs limits below the field range.
      set_limits(15, 15);
      issue(psm_pkg::CMD_WRITE, 20, 3, 0, 0, psm_pkg::CLS_IN);
      issue(psm_pkg::CMD_READ, 3, 200, 0, 0, psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_GROW, 16, 0, 0, 0, psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_CLASSIFY, 0, 0, 200, 3, psm_pkg::CLS_OUT);
      issue(psm_pkg::CMD_COUNT, 0, 0, 0, 0, psm_pkg::CLS_THREE);
      issue(psm_pkg::CMD_COUNT, 0, 0, 0, 0, psm_pkg::CLS_OUT);

      random_phase(15, 15, 300, 1'b1);
      random_phase(0, 0, 60, 1'b1);
      random_phase(255, 3, 110, 1'b1);
      random_phase(7, 255, 110, 1'b1);
      random_phase(255, 255, 40, 1'b0);

      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d requests across %0d grid size settings, both sides idling at random.",
               sent, settings_used + 1);
      if (fail_count == 0 && pending == 0)
         $display("pixel_status_map_rect_grow_unit: match");
      else
         $display("pixel_status_map_rect_grow_unit: mismatch");
      $finish;
   end

endmodule
